[src/rgps_pkg.sv]
// ----------------------------------------------------------------------------
// rgps_pkg
// Shared constants, types and state codes of the radius greedy point
// subsampler.
// ----------------------------------------------------------------------------
package rgps_pkg;

	localparam int MAX_NODES = 2048;
	localparam int ADDR_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int COORD_W   = 24;
	localparam int TAG_W     = 32;
	localparam int RADIUS_W  = 16;
	localparam int R2_W      = 2 * RADIUS_W;
	localparam int SQ_W      = 2 * COORD_W + 1;
	localparam int D2_W      = SQ_W + 2;
	localparam int NODE_W    = 3 * COORD_W + TAG_W;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd557;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [TAG_W-1:0]          tag_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [RADIUS_W-1:0]       radius_t;
	typedef logic [R2_W-1:0]           r2_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		tag_t   tag;
	} node_t;

	typedef struct packed {
		logic busy;
		logic hit;
	} dist_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

[src/cand_if.sv]
// ----------------------------------------------------------------------------
// cand_if
// Candidate point channel: valid/ready handshake with one point per item.
// ----------------------------------------------------------------------------
interface cand_if;
	import rgps_pkg::*;

	logic   valid;
	logic   ready;
	logic   start_new_set;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	tag_t   tag_word;

	modport source (output valid, output start_new_set, output pos_x, output pos_y,
		output pos_z, output tag_word, input ready);
	modport sink (input valid, input start_new_set, input pos_x, input pos_y,
		input pos_z, input tag_word, output ready);

endinterface

[src/res_if.sv]
// ----------------------------------------------------------------------------
// res_if
// Result channel: valid/ready handshake with one decision per item.
// ----------------------------------------------------------------------------
interface res_if;
	import rgps_pkg::*;

	logic  valid;
	logic  ready;
	logic  accepted;
	addr_t node_index;
	cnt_t  node_total;
	logic  store_full;

	modport source (output valid, output accepted, output node_index, output node_total,
		output store_full, input ready);
	modport sink (input valid, input accepted, input node_index, input node_total,
		input store_full, output ready);

endinterface

[src/cfg_if.sv]
// ----------------------------------------------------------------------------
// cfg_if
// Configuration write channel for the sampling radius register.
// ----------------------------------------------------------------------------
interface cfg_if;
	import rgps_pkg::*;

	logic    valid;
	logic    ready;
	radius_t sample_radius;

	modport source (output valid, output sample_radius, input ready);
	modport sink (input valid, input sample_radius, output ready);

endinterface

[src/rgps_ram.sv]
// ----------------------------------------------------------------------------
// rgps_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rgps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/rgps_dist.sv]
// ----------------------------------------------------------------------------
// rgps_dist
// Two-stage squared distance unit: per-axis squares, then sum and compare
// against the squared radius.
// ----------------------------------------------------------------------------
module rgps_dist (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                flush,
	input  logic                vld,
	input  rgps_pkg::coord_t    cand_x,
	input  rgps_pkg::coord_t    cand_y,
	input  rgps_pkg::coord_t    cand_z,
	input  rgps_pkg::node_t     node,
	input  rgps_pkg::r2_t       r2,
	output rgps_pkg::dist_stat_t stat
);
	import rgps_pkg::*;

	logic signed [COORD_W:0]     dx, dy, dz;
	logic signed [2*COORD_W+1:0] sqx, sqy, sqz;
	logic [SQ_W-1:0]             sq_x_s1, sq_y_s1, sq_z_s1;
	logic                        vld_s1, vld_s2;
	logic                        near_s2;
	logic [D2_W-1:0]             d2;

	always_comb begin
		dx  = $signed({cand_x[COORD_W-1], cand_x}) - $signed({node.x[COORD_W-1], node.x});
		dy  = $signed({cand_y[COORD_W-1], cand_y}) - $signed({node.y[COORD_W-1], node.y});
		dz  = $signed({cand_z[COORD_W-1], cand_z}) - $signed({node.z[COORD_W-1], node.z});
		sqx = dx * dx;
		sqy = dy * dy;
		sqz = dz * dz;
	end

	assign d2 = D2_W'(sq_x_s1) + D2_W'(sq_y_s1) + D2_W'(sq_z_s1);

	always_ff @(posedge clk) begin
		sq_x_s1 <= SQ_W'(sqx);
		sq_y_s1 <= SQ_W'(sqy);
		sq_z_s1 <= SQ_W'(sqz);
		near_s2 <= d2 < D2_W'(r2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld && !flush;
			vld_s2 <= vld_s1 && !flush;
		end
	end

	assign stat.busy = vld_s1 | vld_s2;
	assign stat.hit  = vld_s2 & near_s2;

endmodule

[src/radius_greedy_point_subsampler_top.sv]
// ----------------------------------------------------------------------------
// radius_greedy_point_subsampler_top
// Greedy Poisson-disk subsampler over a node memory.
//
// Candidates arrive on the cand channel, one 3D point and tag per item. Each
// candidate is compared with the stored nodes; it becomes a new node when its
// squared distance to all of them is at least the squared radius. One result
// item per candidate leaves on the res channel: accept flag, node index,
// node count and a flag for a qualifying point dropped by a full store.
// The radius is to be written on the cfg channel only while the block is
// idle; the block itself does not enforce this. A candidate is compared
// with the stored nodes at one node memory read per cycle; with an empty
// store no node is read. A near node found early ends the scan.
// One candidate is in work at a time; the next is taken once the previous
// result is in the output register, even if not yet taken.
// If the receiver stalls, the finished decision waits and no further node is
// written until the output register frees. Reset empties the store and sets
// the radius to its reset value; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module radius_greedy_point_subsampler_top (
	input logic clk,
	input logic arst_n,
	cand_if.sink   cand,
	cfg_if.sink    cfg,
	res_if.source  res
);
	import rgps_pkg::*;

	state_t     state_q, state_d;
	radius_t    radius_q;
	r2_t        r2_q;
	coord_t     cx_q, cy_q, cz_q;
	tag_t       tag_q;
	cnt_t       count_q;
	cnt_t       idx_q;
	logic       rd_vld_s1;
	logic       rej_q;
	logic       res_vld_q;
	logic       res_acc_q;
	addr_t      res_idx_q;
	cnt_t       res_total_q;
	logic       res_full_q;

	logic       cand_rdy, issue, fin_fire, out_free, scan_done, room, take;
	node_t      wr_node, rd_node;
	dist_stat_t stat;

	assign out_free  = !res_vld_q || res.ready;
	assign scan_done = (idx_q == count_q) && !rd_vld_s1 && !stat.busy;
	assign room      = count_q != CNT_W'(MAX_NODES);
	assign take      = !rej_q && room;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cand.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.hit || scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		cand_rdy = 1'b0;
		issue    = 1'b0;
		fin_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:   cand_rdy = 1'b1;
			ST_SCAN:   issue    = (idx_q != count_q) && !stat.hit;
			ST_FINISH: fin_fire = out_free;
			default: begin
				cand_rdy = 1'b0;
			end
		endcase
	end

	assign cand.ready = cand_rdy;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			radius_q  <= RADIUS_RESET;
			r2_q      <= R2_W'(RADIUS_RESET) * R2_W'(RADIUS_RESET);
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rej_q     <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			r2_q      <= R2_W'(radius_q) * R2_W'(radius_q);
			rd_vld_s1 <= issue;
			if (cfg.valid) begin
				radius_q <= cfg.sample_radius;
			end
			if (cand_rdy && cand.valid) begin
				idx_q <= '0;
				rej_q <= 1'b0;
				if (cand.start_new_set) begin
					count_q <= '0;
				end
			end
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (state_q == ST_SCAN && stat.hit) begin
				rej_q <= 1'b1;
			end
			if (fin_fire) begin
				count_q   <= count_q + {{(CNT_W-1){1'b0}}, take};
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Candidate and result payload.
	always_ff @(posedge clk) begin
		if (cand_rdy && cand.valid) begin
			cx_q  <= cand.pos_x;
			cy_q  <= cand.pos_y;
			cz_q  <= cand.pos_z;
			tag_q <= cand.tag_word;
		end
		if (fin_fire) begin
			res_acc_q   <= take;
			res_idx_q   <= take ? count_q[ADDR_W-1:0] : '0;
			res_total_q <= count_q + {{(CNT_W-1){1'b0}}, take};
			res_full_q  <= !rej_q && !room;
		end
	end

	assign wr_node = '{x: cx_q, y: cy_q, z: cz_q, tag: tag_q};

	rgps_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES)
	) u_node_ram (
		.clk  (clk),
		.we   (fin_fire && take),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(wr_node),
		.re   (issue),
		.raddr(idx_q[ADDR_W-1:0]),
		.rdata(rd_node)
	);

	// Reads still in flight when the scan ends are dropped by the flush.
	rgps_dist u_dist (
		.clk   (clk),
		.arst_n(arst_n),
		.flush (state_q != ST_SCAN),
		.vld   (rd_vld_s1),
		.cand_x(cx_q),
		.cand_y(cy_q),
		.cand_z(cz_q),
		.node  (rd_node),
		.r2    (r2_q),
		.stat  (stat)
	);

	assign res.valid      = res_vld_q;
	assign res.accepted   = res_acc_q;
	assign res.node_index = res_idx_q;
	assign res.node_total = res_total_q;
	assign res.store_full = res_full_q;

endmodule

[src/rgps_chk.sv]
// ----------------------------------------------------------------------------
// rgps_chk
// Port-level checker for the subsampler result channel, bound to the top.
// ----------------------------------------------------------------------------
module rgps_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic                 res_accepted,
	input rgps_pkg::addr_t      res_node_index,
	input rgps_pkg::cnt_t       res_node_total,
	input logic                 res_store_full
);
	import rgps_pkg::*;

	// A stalled result must stay put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_accepted)
			&& $stable(res_node_index) && $stable(res_node_total)
			&& $stable(res_store_full))
		else $error("result changed while stalled");

	// A new node is always the last one in the store.
	a_acc_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_accepted |->
			res_node_total == {1'b0, res_node_index} + {{(CNT_W-1){1'b0}}, 1'b1}
			&& !res_store_full)
		else $error("accepted node index does not match node total");

	// A dropped point only happens with a full store.
	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_store_full |-> res_node_total == CNT_W'(MAX_NODES))
		else $error("store full flagged below capacity");

	a_rej_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_accepted |-> res_node_index == '0
			&& res_node_total <= CNT_W'(MAX_NODES))
		else $error("rejected item carries a node index");

endmodule

bind radius_greedy_point_subsampler_top rgps_chk u_rgps_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_accepted  (res.accepted),
	.res_node_index(res.node_index),
	.res_node_total(res.node_total),
	.res_store_full(res.store_full)
);
